// File: hdl/ttf_pkg.sv
// shared types and constants for the triangle tangent frame block
package ttf_pkg;

  localparam int unsigned DATA_W  = 32;          // Q16.16 input and Q2.30 output width
  localparam int unsigned DIFF_W  = DATA_W + 1;  // difference of two inputs
  localparam int unsigned PROD_W  = 2 * DIFF_W;  // signed product
  localparam int unsigned COMP_W  = PROD_W + 1;  // difference of two products
  localparam int unsigned MAG_W   = PROD_W;      // magnitude of a component
  localparam int unsigned NORM_W  = 31;          // normalized magnitude width
  localparam int unsigned ROOT_W  = 32;
  localparam int unsigned SUM_W   = 64;
  localparam int unsigned REM_W   = ROOT_W + 4;
  localparam int unsigned STEPS   = 4;           // result bits per cycle in root and divide
  localparam int unsigned ITERS   = ROOT_W / STEPS;

  typedef logic signed [DIFF_W-1:0] diff_t;
  typedef logic signed [DATA_W-1:0] word_t;

  // edge vectors and texture deltas of one triangle
  typedef struct packed {
    diff_t e1x;
    diff_t e1y;
    diff_t e1z;
    diff_t e2x;
    diff_t e2y;
    diff_t e2z;
    diff_t du1;
    diff_t dv1;
    diff_t du2;
    diff_t dv2;
  } tri_t;

endpackage

// File: hdl/ttf_if.sv
// channel interfaces for vertices in and tangent frames out
interface ttf_in_if;
  logic                 valid;
  logic                 ready;
  ttf_pkg::word_t       pos_x;
  ttf_pkg::word_t       pos_y;
  ttf_pkg::word_t       pos_z;
  ttf_pkg::word_t       tex_u;
  ttf_pkg::word_t       tex_v;
  modport source (output valid, pos_x, pos_y, pos_z, tex_u, tex_v, input ready);
  modport sink   (input valid, pos_x, pos_y, pos_z, tex_u, tex_v, output ready);
endinterface

interface ttf_out_if;
  logic                 valid;
  logic                 ready;
  ttf_pkg::word_t       tangent_x;
  ttf_pkg::word_t       tangent_y;
  ttf_pkg::word_t       tangent_z;
  ttf_pkg::word_t       bitangent_x;
  ttf_pkg::word_t       bitangent_y;
  ttf_pkg::word_t       bitangent_z;
  logic                 tangent_degenerate;
  logic                 bitangent_degenerate;
  modport source (output valid, tangent_x, tangent_y, tangent_z, bitangent_x, bitangent_y,
                  bitangent_z, tangent_degenerate, bitangent_degenerate, input ready);
  modport sink   (input valid, tangent_x, tangent_y, tangent_z, bitangent_x, bitangent_y,
                  bitangent_z, tangent_degenerate, bitangent_degenerate, output ready);
endinterface

// File: hdl/ttf_front.sv
// front end: collects three vertices and forms edge and texture deltas
module ttf_front (
  input  logic            clk,
  input  logic            rst_n,
  ttf_in_if.sink          in_vtx,
  output logic            push_valid,
  input  logic            push_ready,
  output ttf_pkg::tri_t   push_data
);

  logic [1:0]        phase_r;
  ttf_pkg::word_t    p0x_r, p0y_r, p0z_r, p1x_r, p1y_r, p1z_r;
  ttf_pkg::word_t    u0_r, v0_r, u1_r, v1_r;
  logic              third;
  logic              xfer;

  assign third        = (phase_r == 2'd2);
  assign in_vtx.ready = !third || push_ready;
  assign push_valid   = in_vtx.valid && third;
  assign xfer         = in_vtx.valid && in_vtx.ready;

  function automatic ttf_pkg::diff_t sub(input ttf_pkg::word_t a, input ttf_pkg::word_t b);
    sub = ttf_pkg::diff_t'({a[31], a}) - ttf_pkg::diff_t'({b[31], b});
  endfunction

  always_comb begin
    push_data.e1x = sub(p1x_r, p0x_r);
    push_data.e1y = sub(p1y_r, p0y_r);
    push_data.e1z = sub(p1z_r, p0z_r);
    push_data.e2x = sub(in_vtx.pos_x, p0x_r);
    push_data.e2y = sub(in_vtx.pos_y, p0y_r);
    push_data.e2z = sub(in_vtx.pos_z, p0z_r);
    push_data.du1 = sub(u1_r, u0_r);
    push_data.dv1 = sub(v1_r, v0_r);
    push_data.du2 = sub(in_vtx.tex_u, u0_r);
    push_data.dv2 = sub(in_vtx.tex_v, v0_r);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      phase_r <= 2'd0;
    end else if (xfer) begin
      if (third) begin
        phase_r <= 2'd0;
      end else if (phase_r == 2'd1) begin
        phase_r <= 2'd2;
      end else begin
        phase_r <= 2'd1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (xfer && !third) begin
      if (phase_r == 2'd1) begin
        p1x_r <= in_vtx.pos_x;
        p1y_r <= in_vtx.pos_y;
        p1z_r <= in_vtx.pos_z;
        u1_r  <= in_vtx.tex_u;
        v1_r  <= in_vtx.tex_v;
      end else begin
        p0x_r <= in_vtx.pos_x;
        p0y_r <= in_vtx.pos_y;
        p0z_r <= in_vtx.pos_z;
        u0_r  <= in_vtx.tex_u;
        v0_r  <= in_vtx.tex_v;
      end
    end
  end

endmodule

// File: hdl/ttf_queue.sv
// two-entry queue of triangles between front and back
module ttf_queue (
  input  logic            clk,
  input  logic            rst_n,
  input  logic            wr_valid,
  output logic            wr_ready,
  input  ttf_pkg::tri_t   wr_data,
  output logic            rd_valid,
  input  logic            rd_ready,
  output ttf_pkg::tri_t   rd_data
);

  ttf_pkg::tri_t mem_r [0:1];
  logic          wr_ptr_r;
  logic          rd_ptr_r;
  logic [1:0]    cnt_r;
  logic          do_wr;
  logic          do_rd;

  assign wr_ready = (cnt_r != 2'd2);
  assign rd_valid = (cnt_r != 2'd0);
  assign rd_data  = mem_r[rd_ptr_r];
  assign do_wr    = wr_valid && wr_ready;
  assign do_rd    = rd_valid && rd_ready;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= 1'b0;
      rd_ptr_r <= 1'b0;
      cnt_r    <= 2'd0;
    end else begin
      if (do_wr) wr_ptr_r <= !wr_ptr_r;
      if (do_rd) rd_ptr_r <= !rd_ptr_r;
      if (do_wr && !do_rd) begin
        cnt_r <= cnt_r + 2'd1;
      end else if (do_rd && !do_wr) begin
        cnt_r <= cnt_r - 2'd1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (do_wr) mem_r[wr_ptr_r] <= wr_data;
  end

`ifndef NO_ASSERTIONS
  a_cnt_range: assert property (@(posedge clk) disable iff (!rst_n) cnt_r != 2'd3)
    else $error("queue count out of range");
  a_ptr_gap: assert property (@(posedge clk) disable iff (!rst_n)
    (cnt_r == 2'd1) |-> (wr_ptr_r != rd_ptr_r))
    else $error("queue pointers disagree with count");
  a_full_ptrs: assert property (@(posedge clk) disable iff (!rst_n)
    (cnt_r != 2'd1) |-> (wr_ptr_r == rd_ptr_r))
    else $error("queue pointers disagree with count");
`endif

endmodule

// File: hdl/ttf_back.sv
// back end: cross products, normalization, square root, division and output register
module ttf_back (
  input  logic            clk,
  input  logic            rst_n,
  input  logic            pop_valid,
  output logic            pop_ready,
  input  ttf_pkg::tri_t   pop_data,
  ttf_out_if.source       out_frame
);

  typedef enum logic [3:0] {
    S_IDLE, S_MUL, S_PREP, S_SHIFT, S_SQ, S_SQRT, S_DINIT, S_DIV, S_STORE, S_OUT
  } state_t;

  state_t                              state_r;
  ttf_pkg::tri_t                       tri_r;
  logic [3:0]                          k_r;
  logic [2:0]                          cnt_r;
  logic signed [ttf_pkg::PROD_W-1:0]   prod_r;
  logic signed [ttf_pkg::COMP_W-1:0]   comp_r [0:5];
  logic                                vec_r;
  logic [ttf_pkg::MAG_W-1:0]           mag_r  [0:2];
  logic                                neg_r  [0:2];
  logic [1:0]                          degen_r;
  logic [2*ttf_pkg::NORM_W-1:0]        sqp_r;
  logic [ttf_pkg::SUM_W-1:0]           sum_r;
  logic [ttf_pkg::SUM_W-1:0]           x_r;
  logic [ttf_pkg::REM_W-1:0]           rem_r;
  logic [ttf_pkg::ROOT_W-1:0]          root_r;
  logic [ttf_pkg::ROOT_W-1:0]          drem_r [0:2];
  logic [ttf_pkg::ROOT_W-1:0]          dlow_r [0:2];
  logic [ttf_pkg::ROOT_W-1:0]          quot_r [0:2];
  ttf_pkg::word_t                      res_r  [0:5];
  logic                                out_valid_r;
  ttf_pkg::word_t                      out_r  [0:5];
  logic [1:0]                          out_deg_r;

  ttf_pkg::diff_t                      opa, opb;
  logic signed [ttf_pkg::PROD_W-1:0]   prod_nxt;
  logic [ttf_pkg::MAG_W-1:0]           orw;
  logic [ttf_pkg::NORM_W-1:0]          msel;
  logic [ttf_pkg::SUM_W-1:0]           x_nxt;
  logic [ttf_pkg::REM_W-1:0]           rem_nxt;
  logic [ttf_pkg::ROOT_W-1:0]          root_nxt;
  logic [ttf_pkg::REM_W-1:0]           trial;
  logic [ttf_pkg::ROOT_W-1:0]          drem_nxt [0:2];
  logic [ttf_pkg::ROOT_W-1:0]          dlow_nxt [0:2];
  logic [ttf_pkg::ROOT_W-1:0]          quot_nxt [0:2];
  logic [ttf_pkg::ROOT_W:0]            dsh;
  logic [2:0]                          cidx;

  assign pop_ready = (state_r == S_IDLE);
  assign orw       = mag_r[0] | mag_r[1] | mag_r[2];
  assign msel      = mag_r[cnt_r[1:0]][ttf_pkg::NORM_W-1:0];
  assign cidx      = 3'((k_r - 4'd1) >> 1);

  // operands of the twelve cross products
  always_comb begin
    case (k_r)
      4'd0:    begin opa = tri_r.dv2; opb = tri_r.e1x; end
      4'd1:    begin opa = tri_r.dv1; opb = tri_r.e2x; end
      4'd2:    begin opa = tri_r.dv2; opb = tri_r.e1y; end
      4'd3:    begin opa = tri_r.dv1; opb = tri_r.e2y; end
      4'd4:    begin opa = tri_r.dv2; opb = tri_r.e1z; end
      4'd5:    begin opa = tri_r.dv1; opb = tri_r.e2z; end
      4'd6:    begin opa = tri_r.du1; opb = tri_r.e2x; end
      4'd7:    begin opa = tri_r.du2; opb = tri_r.e1x; end
      4'd8:    begin opa = tri_r.du1; opb = tri_r.e2y; end
      4'd9:    begin opa = tri_r.du2; opb = tri_r.e1y; end
      4'd10:   begin opa = tri_r.du1; opb = tri_r.e2z; end
      4'd11:   begin opa = tri_r.du2; opb = tri_r.e1z; end
      default: begin opa = '0; opb = '0; end
    endcase
    prod_nxt = opa * opb;
  end

  // square root: digit-by-digit, several result bits per cycle
  always_comb begin
    x_nxt    = x_r;
    rem_nxt  = rem_r;
    root_nxt = root_r;
    trial    = '0;
    for (int s = 0; s < ttf_pkg::STEPS; s++) begin
      rem_nxt = {rem_nxt[ttf_pkg::REM_W-3:0], x_nxt[ttf_pkg::SUM_W-1 -: 2]};
      x_nxt   = {x_nxt[ttf_pkg::SUM_W-3:0], 2'b00};
      trial   = {2'b00, root_nxt, 2'b01};
      if (rem_nxt >= trial) begin
        rem_nxt  = rem_nxt - trial;
        root_nxt = {root_nxt[ttf_pkg::ROOT_W-2:0], 1'b1};
      end else begin
        root_nxt = {root_nxt[ttf_pkg::ROOT_W-2:0], 1'b0};
      end
    end
  end

  // three restoring divider lanes sharing the root as divisor
  always_comb begin
    dsh = '0;
    for (int i = 0; i < 3; i++) begin
      drem_nxt[i] = drem_r[i];
      dlow_nxt[i] = dlow_r[i];
      quot_nxt[i] = quot_r[i];
      for (int s = 0; s < ttf_pkg::STEPS; s++) begin
        dsh         = {drem_nxt[i], dlow_nxt[i][ttf_pkg::ROOT_W-1]};
        dlow_nxt[i] = {dlow_nxt[i][ttf_pkg::ROOT_W-2:0], 1'b0};
        if (dsh >= {1'b0, root_r}) begin
          dsh         = dsh - {1'b0, root_r};
          quot_nxt[i] = {quot_nxt[i][ttf_pkg::ROOT_W-2:0], 1'b1};
        end else begin
          quot_nxt[i] = {quot_nxt[i][ttf_pkg::ROOT_W-2:0], 1'b0};
        end
        drem_nxt[i] = dsh[ttf_pkg::ROOT_W-1:0];
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      out_valid_r <= 1'b0;
    end else begin
      if (out_valid_r && out_frame.ready && state_r != S_OUT) out_valid_r <= 1'b0;
      case (state_r)
        S_IDLE: begin
          if (pop_valid) begin
            tri_r   <= pop_data;
            k_r     <= 4'd0;
            state_r <= S_MUL;
          end
        end
        S_MUL: begin
          prod_r <= prod_nxt;
          if (k_r != 4'd0) begin
            if (!k_r[0]) begin
              comp_r[cidx] <= comp_r[cidx] - ttf_pkg::COMP_W'(prod_r);
            end else begin
              comp_r[cidx] <= ttf_pkg::COMP_W'(prod_r);
            end
          end
          k_r <= k_r + 4'd1;
          if (k_r == 4'd12) begin
            vec_r   <= 1'b0;
            state_r <= S_PREP;
          end
        end
        S_PREP: begin
          for (int i = 0; i < 3; i++) begin
            if (vec_r) begin
              neg_r[i] <= comp_r[3+i][ttf_pkg::COMP_W-1];
              mag_r[i] <= comp_r[3+i][ttf_pkg::COMP_W-1]
                          ? ttf_pkg::MAG_W'(-comp_r[3+i])
                          : ttf_pkg::MAG_W'(comp_r[3+i]);
            end else begin
              neg_r[i] <= comp_r[i][ttf_pkg::COMP_W-1];
              mag_r[i] <= comp_r[i][ttf_pkg::COMP_W-1]
                          ? ttf_pkg::MAG_W'(-comp_r[i])
                          : ttf_pkg::MAG_W'(comp_r[i]);
            end
          end
          state_r <= S_SHIFT;
        end
        S_SHIFT: begin
          // bring the largest magnitude to exactly 31 bits, truncating on the way down
          if (orw == '0) begin
            degen_r[vec_r] <= 1'b1;
            state_r        <= S_STORE;
          end else if (orw[65:47] != '0) begin
            for (int i = 0; i < 3; i++) mag_r[i] <= mag_r[i] >> 16;
          end else if (orw[65:35] != '0) begin
            for (int i = 0; i < 3; i++) mag_r[i] <= mag_r[i] >> 4;
          end else if (orw[65:31] != '0) begin
            for (int i = 0; i < 3; i++) mag_r[i] <= mag_r[i] >> 1;
          end else if (orw[30:15] == '0) begin
            for (int i = 0; i < 3; i++) mag_r[i] <= mag_r[i] << 16;
          end else if (orw[30:27] == '0) begin
            for (int i = 0; i < 3; i++) mag_r[i] <= mag_r[i] << 4;
          end else if (!orw[30]) begin
            for (int i = 0; i < 3; i++) mag_r[i] <= mag_r[i] << 1;
          end else begin
            degen_r[vec_r] <= 1'b0;
            cnt_r          <= 3'd0;
            state_r        <= S_SQ;
          end
        end
        S_SQ: begin
          sqp_r <= (2*ttf_pkg::NORM_W)'(msel) * (2*ttf_pkg::NORM_W)'(msel);
          if (cnt_r == 3'd0) begin
            sum_r <= '0;
          end else begin
            sum_r <= sum_r + ttf_pkg::SUM_W'(sqp_r);
          end
          cnt_r <= cnt_r + 3'd1;
          if (cnt_r == 3'd3) begin
            x_r     <= sum_r + ttf_pkg::SUM_W'(sqp_r);
            rem_r   <= '0;
            root_r  <= '0;
            cnt_r   <= 3'd0;
            state_r <= S_SQRT;
          end
        end
        S_SQRT: begin
          x_r    <= x_nxt;
          rem_r  <= rem_nxt;
          root_r <= root_nxt;
          cnt_r  <= cnt_r + 3'd1;
          if (cnt_r == 3'(ttf_pkg::ITERS - 1)) state_r <= S_DINIT;
        end
        S_DINIT: begin
          // numerator m * 2^30 + floor(r / 2); the top part is already below r
          for (int i = 0; i < 3; i++) begin
            drem_r[i] <= ttf_pkg::ROOT_W'((62'({mag_r[i][30:0], 30'd0})
                                           + 62'(root_r >> 1)) >> 32);
            dlow_r[i] <= ttf_pkg::ROOT_W'(62'({mag_r[i][30:0], 30'd0})
                                          + 62'(root_r >> 1));
            quot_r[i] <= '0;
          end
          cnt_r   <= 3'd0;
          state_r <= S_DIV;
        end
        S_DIV: begin
          for (int i = 0; i < 3; i++) begin
            drem_r[i] <= drem_nxt[i];
            dlow_r[i] <= dlow_nxt[i];
            quot_r[i] <= quot_nxt[i];
          end
          cnt_r <= cnt_r + 3'd1;
          if (cnt_r == 3'(ttf_pkg::ITERS - 1)) state_r <= S_STORE;
        end
        S_STORE: begin
          for (int i = 0; i < 3; i++) begin
            if (degen_r[vec_r]) begin
              res_r[(vec_r ? 3 : 0) + i] <= '0;
            end else begin
              res_r[(vec_r ? 3 : 0) + i] <= neg_r[i] ? ttf_pkg::word_t'(32'd0 - quot_r[i])
                                                     : ttf_pkg::word_t'(quot_r[i]);
            end
          end
          if (vec_r) begin
            state_r <= S_OUT;
          end else begin
            vec_r   <= 1'b1;
            state_r <= S_PREP;
          end
        end
        S_OUT: begin
          if (!out_valid_r || out_frame.ready) begin
            for (int i = 0; i < 6; i++) out_r[i] <= res_r[i];
            out_deg_r   <= degen_r;
            out_valid_r <= 1'b1;
            state_r     <= S_IDLE;
          end
        end
        default: state_r <= S_IDLE;
      endcase
    end
  end

  assign out_frame.valid                = out_valid_r;
  assign out_frame.tangent_x            = out_r[0];
  assign out_frame.tangent_y            = out_r[1];
  assign out_frame.tangent_z            = out_r[2];
  assign out_frame.bitangent_x          = out_r[3];
  assign out_frame.bitangent_y          = out_r[4];
  assign out_frame.bitangent_z          = out_r[5];
  assign out_frame.tangent_degenerate   = out_deg_r[0];
  assign out_frame.bitangent_degenerate = out_deg_r[1];

`ifndef NO_ASSERTIONS
  a_norm_width: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == S_SQ) |-> (orw[65:31] == '0 && orw[30]))
    else $error("normalized magnitude is not 31 bits wide");
  a_root_range: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == S_DIV) |-> (root_r[31:30] != 2'b00))
    else $error("root below 2^30 for a nonzero vector");
  a_quot_range: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == S_STORE && !degen_r[vec_r]) |->
      (quot_r[0] <= 32'h4000_0000 && quot_r[1] <= 32'h4000_0000 &&
       quot_r[2] <= 32'h4000_0000))
    else $error("unit component above one");
`endif

endmodule

// File: hdl/triangle_tangent_frame_core.sv
// top level of the per-face tangent and bitangent block
// Usage:
//   in_vtx carries one vertex per transfer: position and texture coordinate,
//   all signed Q16.16. Every three vertices form one triangle.
//   out_frame carries one result per triangle: unit tangent and bitangent in
//   signed Q2.30 plus a degenerate flag for each, set when that vector had
//   zero length and its components are given as zero.
//   The first two vertices of a triangle are taken one per cycle. The third
//   goes into a two-entry triangle queue and is taken while the queue has room.
// Processing order:
//   the back end uses one multiplier for 12 cross products, then for each
//   vector a block shift, squares, square root and three divider lanes at
//   4 bits per cycle; a zero-length vector skips squares, root and division.
//   The back end takes a new triangle from the queue only when idle, so it
//   finishes one triangle before it starts the next.
// Reset clears the vertex count, the queue and the output valid.
// When the receiver stalls the result waits in the output register; the back
// end finishes the next triangle and the front end keeps filling the queue.
module triangle_tangent_frame_core (
  input  logic       clk,
  input  logic       rst_n,
  ttf_in_if.sink     in_vtx,
  ttf_out_if.source  out_frame
);

  logic           push_valid;
  logic           push_ready;
  ttf_pkg::tri_t  push_data;
  logic           pop_valid;
  logic           pop_ready;
  ttf_pkg::tri_t  pop_data;

  ttf_front u_front (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_vtx     (in_vtx),
    .push_valid (push_valid),
    .push_ready (push_ready),
    .push_data  (push_data)
  );

  ttf_queue u_queue (
    .clk      (clk),
    .rst_n    (rst_n),
    .wr_valid (push_valid),
    .wr_ready (push_ready),
    .wr_data  (push_data),
    .rd_valid (pop_valid),
    .rd_ready (pop_ready),
    .rd_data  (pop_data)
  );

  ttf_back u_back (
    .clk       (clk),
    .rst_n     (rst_n),
    .pop_valid (pop_valid),
    .pop_ready (pop_ready),
    .pop_data  (pop_data),
    .out_frame (out_frame)
  );

endmodule
